// File: hw/rtl/binary_heap_sorter_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the binary heap sorter
// Concurrent checks written through these macros disappear in synthesis.
// ---------------------------------------------------------------------------
`ifndef BINARY_HEAP_SORTER_DEFINES_SVH
`define BINARY_HEAP_SORTER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on the rising clock edge.
`define BHS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define BHS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define BHS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define BHS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// File: hw/rtl/bhs_pkg.sv
// ---------------------------------------------------------------------------
// Binary heap sorter package
// Shared constants, the sift decision type and the ordering function.
// ---------------------------------------------------------------------------
`default_nettype none

package bhs_pkg;

   localparam int DATA_W        = 32;
   localparam int DEPTH_DEFAULT = 64;

   // Outcome of one sift-down level: whether a child moves up, and which one.
   typedef struct packed {
      logic move;
      logic right;
   } pick_type;

   // True when value a must sit above value b in the heap.
   function automatic logic ranks_ahead(input logic [DATA_W-1:0] a,
                                        input logic [DATA_W-1:0] b,
                                        input logic               min_mode);
      logic result;
      if (min_mode) begin
         result = $signed(a) < $signed(b);
      end else begin
         result = $signed(a) > $signed(b);
      end
      return result;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/bhs_mem.sv
// ---------------------------------------------------------------------------
// Heap storage
// One write port and two read ports, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module bhs_mem #(
   parameter int DEPTH = bhs_pkg::DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [AW-1:0]             wr_addr,
   input  wire logic [bhs_pkg::DATA_W-1:0] wr_data,
   input  wire logic [AW-1:0]             rd_addr_a,
   input  wire logic [AW-1:0]             rd_addr_b,
   output logic      [bhs_pkg::DATA_W-1:0] rd_data_a,
   output logic      [bhs_pkg::DATA_W-1:0] rd_data_b
);

   logic [bhs_pkg::DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

`default_nettype wire

// File: hw/rtl/bhs_pick.sv
// ---------------------------------------------------------------------------
// Sift-down decision
// Chooses among a node and its two children which value belongs on top.
// ---------------------------------------------------------------------------
`default_nettype none

module bhs_pick (
   input  wire logic                       min_mode,
   input  wire logic [bhs_pkg::DATA_W-1:0] node_val,
   input  wire logic [bhs_pkg::DATA_W-1:0] left_val,
   input  wire logic [bhs_pkg::DATA_W-1:0] right_val,
   input  wire logic                       left_ok,
   input  wire logic                       right_ok,
   output bhs_pkg::pick_type               pick
);

   logic left_beats_node;
   logic right_beats_node;
   logic right_beats_left;

   // The three compares run side by side; the choice below is a small mux.
   assign left_beats_node  = left_ok && bhs_pkg::ranks_ahead(left_val, node_val, min_mode);
   assign right_beats_node = right_ok && bhs_pkg::ranks_ahead(right_val, node_val, min_mode);
   assign right_beats_left = right_ok && bhs_pkg::ranks_ahead(right_val, left_val, min_mode);

   always_comb begin
      priority if (left_beats_node) begin
         pick.move  = 1'b1;
         pick.right = right_beats_left;
      end else if (right_beats_node) begin
         pick.move  = 1'b1;
         pick.right = 1'b1;
      end else begin
         pick.move  = 1'b0;
         pick.right = 1'b0;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/binary_heap_sorter.sv
// Loading accepts one item per cycle; the store holds up to DEPTH values.
// After the closing item, each sift-down level reads the children, then compares and writes
// back in the storage; building reads and loads each inner node before its sift, and each
// sort step reads the top and the last value and swaps them before sifting from the root.
// Results leave one by one via the single read port in use, held while the output stalls.
// Reset (synchronous, active high) returns to loading with zero count and order 0.
// ---------------------------------------------------------------------------
// Binary heap sorter
// Collects a set of signed values, heapsorts it in place in a local memory
// and streams the sorted set out, with the final value marked by tlast.
// ---------------------------------------------------------------------------
`default_nettype none

`include "binary_heap_sorter_defines.svh"

module binary_heap_sorter #(
   parameter int DEPTH = bhs_pkg::DEPTH_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // Configuration: order bit, 0 max-heap (ascending), 1 min-heap (descending).
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic                       csr_wdata,
   // Input stream. tdata: in_value[31:0]. tlast: in_last.
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [bhs_pkg::DATA_W-1:0] req_tdata,
   input  wire logic                       req_tlast,
   // Result stream. tdata: out_value[31:0]. tlast: out_last.
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic      [bhs_pkg::DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CNTW = $clog2(DEPTH + 1);
   localparam int CW   = CNTW + 1;

   typedef enum logic [8:0] {
      ST_LOAD      = 9'b000000001,
      ST_BUILD_RD  = 9'b000000010,
      ST_BUILD_LD  = 9'b000000100,
      ST_SIFT_RD   = 9'b000001000,
      ST_SIFT_CMP  = 9'b000010000,
      ST_SORT_RD   = 9'b000100000,
      ST_SORT_SWAP = 9'b001000000,
      ST_EMIT_RD   = 9'b010000000,
      ST_EMIT_LD   = 9'b100000000
   } state_type;

   state_type                  state_ff, state_in;
   logic [CNTW-1:0]            count_ff, count_in;
   logic [CNTW-1:0]            iter_ff, iter_in;
   logic [CNTW-1:0]            node_ff, node_in;
   logic [CNTW-1:0]            size_ff, size_in;
   logic [CNTW-1:0]            emit_ff, emit_in;
   logic                       sorting_ff, sorting_in;
   logic [bhs_pkg::DATA_W-1:0] val_ff, val_in;
   logic                       order_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [bhs_pkg::DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   logic [bhs_pkg::DATA_W-1:0] wr_data;
   logic [AW-1:0]              rd_addr_a;
   logic [AW-1:0]              rd_addr_b;
   logic [bhs_pkg::DATA_W-1:0] rd_data_a;
   logic [bhs_pkg::DATA_W-1:0] rd_data_b;

   logic [CW-1:0]              left_idx;
   logic [CW-1:0]              right_idx;
   logic [CW-1:0]              child_idx;
   logic                       left_ok;
   logic                       right_ok;
   logic                       req_accept;
   logic                       out_free;
   logic [CNTW-1:0]            count_inc;
   bhs_pkg::pick_type          pick;

   bhs_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   bhs_pick u_pick (
      .min_mode  (order_ff),
      .node_val  (val_ff),
      .left_val  (rd_data_a),
      .right_val (rd_data_b),
      .left_ok   (left_ok),
      .right_ok  (right_ok),
      .pick      (pick)
   );

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_LOAD);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign count_inc  = count_ff + CNTW'(1);

   // Heap positions are 1-based; memory addresses are position minus one.
   assign left_idx  = {node_ff, 1'b0};
   assign right_idx = {node_ff, 1'b1};
   assign left_ok   = left_idx <= {1'b0, size_ff};
   assign right_ok  = right_idx <= {1'b0, size_ff};
   assign child_idx = pick.right ? right_idx : left_idx;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      iter_in      = iter_ff;
      node_in      = node_ff;
      size_in      = size_ff;
      emit_in      = emit_ff;
      sorting_in   = sorting_ff;
      val_in       = val_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = val_ff;
      rd_addr_a    = '0;
      rd_addr_b    = '0;

      unique case (state_ff)
         ST_LOAD: begin
            wr_en   = req_accept;
            wr_addr = count_ff[AW-1:0];
            wr_data = req_tdata;
            if (req_accept) begin
               count_in = count_inc;
               // A full store closes the set just like a marked last item.
               if (req_tlast || (count_inc == CNTW'(DEPTH))) begin
                  iter_in = count_inc >> 1;
                  emit_in = CNTW'(1);
                  if (count_inc == CNTW'(1)) begin
                     state_in = ST_EMIT_RD;
                  end else begin
                     state_in = ST_BUILD_RD;
                  end
               end
            end
         end
         ST_BUILD_RD: begin
            rd_addr_a = AW'(iter_ff - CNTW'(1));
            state_in  = ST_BUILD_LD;
         end
         ST_BUILD_LD: begin
            val_in     = rd_data_a;
            node_in    = iter_ff;
            size_in    = count_ff;
            sorting_in = 1'b0;
            state_in   = ST_SIFT_RD;
         end
         ST_SIFT_RD: begin
            rd_addr_a = left_ok ? AW'(left_idx - CW'(1)) : '0;
            rd_addr_b = right_ok ? AW'(right_idx - CW'(1)) : '0;
            state_in  = ST_SIFT_CMP;
         end
         ST_SIFT_CMP: begin
            // The carried value leaves a hole that moves down; a winning child
            // fills the hole, otherwise the carried value settles here.
            wr_en   = 1'b1;
            wr_addr = AW'(node_ff - CNTW'(1));
            if (pick.move) begin
               wr_data  = pick.right ? rd_data_b : rd_data_a;
               node_in  = child_idx[CNTW-1:0];
               state_in = ST_SIFT_RD;
            end else begin
               wr_data = val_ff;
               if (!sorting_ff) begin
                  if (iter_ff == CNTW'(1)) begin
                     iter_in  = count_ff;
                     state_in = ST_SORT_RD;
                  end else begin
                     iter_in  = iter_ff - CNTW'(1);
                     state_in = ST_BUILD_RD;
                  end
               end else begin
                  if (iter_ff == CNTW'(2)) begin
                     state_in = ST_EMIT_RD;
                  end else begin
                     iter_in  = iter_ff - CNTW'(1);
                     state_in = ST_SORT_RD;
                  end
               end
            end
         end
         ST_SORT_RD: begin
            rd_addr_a = '0;
            rd_addr_b = AW'(iter_ff - CNTW'(1));
            state_in  = ST_SORT_SWAP;
         end
         ST_SORT_SWAP: begin
            // The top moves to the end of the heap; the old last value sifts from the root.
            wr_en      = 1'b1;
            wr_addr    = AW'(iter_ff - CNTW'(1));
            wr_data    = rd_data_a;
            val_in     = rd_data_b;
            node_in    = CNTW'(1);
            size_in    = iter_ff - CNTW'(1);
            sorting_in = 1'b1;
            state_in   = ST_SIFT_RD;
         end
         ST_EMIT_RD: begin
            rd_addr_a = AW'(emit_ff - CNTW'(1));
            state_in  = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            // The address is held so the read data stays put while the output stalls.
            rd_addr_a = AW'(emit_ff - CNTW'(1));
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = rd_data_a;
               rsp_last_in  = (emit_ff == count_ff);
               if (emit_ff == count_ff) begin
                  count_in = '0;
                  state_in = ST_LOAD;
               end else begin
                  emit_in  = emit_ff + CNTW'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         order_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            order_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      iter_ff     <= iter_in;
      node_ff     <= node_in;
      size_ff     <= size_in;
      emit_ff     <= emit_in;
      sorting_ff  <= sorting_in;
      val_ff      <= val_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   `BHS_ASSERT_NEXT(a_full_closes_set, clock, reset,
      req_accept && (count_ff == CNTW'(DEPTH - 1)), state_ff != ST_LOAD,
      "filling the last position did not close the set")

   `BHS_ASSERT_NOW(a_sift_node_in_heap, clock, reset,
      state_ff == ST_SIFT_CMP, (node_ff != '0) && (node_ff <= size_ff) && (size_ff <= count_ff),
      "sift node outside the current heap")

   `BHS_ASSERT_NOW(a_emit_index_range, clock, reset,
      state_ff == ST_EMIT_LD, (emit_ff != '0) && (emit_ff <= count_ff),
      "emit index outside the loaded set")

endmodule

`default_nettype wire

// File: test/tb_binary_heap_sorter.sv
// ---------------------------------------------------------------------------
// Binary heap sorter testbench
// Streams sets of signed values into the sorter under both order settings.
// A local model keeps each open set in sorted order and queues the expected
// output when the set closes, either on tlast or on a full store. Every
// result transaction is compared field by field against that queue.
// ---------------------------------------------------------------------------
module tb_binary_heap_sorter;

   localparam int CLOCK_PERIOD  = 10;
   localparam int RESET_CYCLES  = 10;
   localparam int SET_DEPTH     = bhs_pkg::DEPTH_DEFAULT;
   localparam int SETTLE_CYCLES = 50;
   localparam int TAIL_CYCLES   = 200;
   localparam int LONG_HOLD     = 500;
   localparam int CYCLE_LIMIT   = 1_000_000;

   localparam logic ORDER_ASCENDING  = 1'b0;
   localparam logic ORDER_DESCENDING = 1'b1;

   typedef struct packed {
      logic [bhs_pkg::DATA_W-1:0] value;
      logic                       last;
   } heap_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       csr_valid = 1'b0;
   logic                       csr_wdata = 1'b0;
   logic                       csr_ready;
   logic                       req_tvalid = 1'b0;
   logic [bhs_pkg::DATA_W-1:0] req_tdata  = '0;
   logic                       req_tlast  = 1'b0;
   logic                       req_tready;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [bhs_pkg::DATA_W-1:0] rsp_tdata;
   logic                       rsp_tlast;

   // Values waiting to be offered, and sorted values waiting to come back.
   heap_word_type pending_items[$];
   heap_word_type sorted_expect[$];

   // Model state: the open set, kept in ascending signed order.
   logic [bhs_pkg::DATA_W-1:0] set_values[0:SET_DEPTH-1];
   int unsigned                set_count  = 0;
   logic                       descending = ORDER_ASCENDING;

   int unsigned tx_idle_pct = 0;
   int unsigned rx_idle_pct = 0;
   logic        pressure_on = 1'b0;
   logic        hold_done   = 1'b0;
   int unsigned hold_left   = 0;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;

   binary_heap_sorter #(
      .DEPTH(SET_DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Adds one accepted value to the open set; a closing value releases the
   // whole set in the selected order.
   task automatic sort_into_set(input logic [bhs_pkg::DATA_W-1:0] value, input logic last);
      int unsigned slot;
      int unsigned n;
      int unsigned pos;
      slot = set_count;
      while (slot > 0 && $signed(set_values[slot-1]) > $signed(value)) begin
         set_values[slot] = set_values[slot-1];
         slot--;
      end
      set_values[slot] = value;
      set_count++;
      if (last || set_count == SET_DEPTH) begin
         n = set_count;
         for (int unsigned k = 0; k < n; k++) begin
            pos = (descending == ORDER_DESCENDING) ? n - 1 - k : k;
            sorted_expect.push_back('{value: set_values[pos], last: k == n - 1});
         end
         set_count = 0;
      end
   endtask

   task automatic queue_item(input logic [bhs_pkg::DATA_W-1:0] value, input logic last);
      pending_items.push_back('{value: value, last: last});
   endtask

   function automatic logic [bhs_pkg::DATA_W-1:0] pick_value();
      int unsigned r;
      logic [bhs_pkg::DATA_W-1:0] v;
      r = $urandom_range(99);
      if (r < 60) begin
         v = $urandom;
      end else if (r < 85) begin
         // Narrow range so that sets carry many equal values.
         v = $urandom_range(8) - 4;
      end else begin
         case ($urandom_range(3))
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = 32'h0000_0000;
            default: v = 32'hFFFF_FFFF;
         endcase
      end
      return v;
   endfunction

   // Whole sets only, mostly short; a few fill the store, with or without tlast.
   task automatic queue_random_sets(input int unsigned target);
      int unsigned queued;
      int unsigned len;
      int unsigned r;
      queued = 0;
      while (queued < target) begin
         r = $urandom_range(99);
         if (r < 70) begin
            len = $urandom_range(8, 1);
         end else if (r < 90) begin
            len = $urandom_range(32, 9);
         end else if (r < 96) begin
            len = $urandom_range(SET_DEPTH - 1, 33);
         end else begin
            len = SET_DEPTH;
         end
         for (int unsigned k = 1; k <= len; k++) begin
            queue_item(pick_value(), k == len && (len < SET_DEPTH || $urandom_range(1) == 1));
         end
         queued += len;
      end
   endtask

   task automatic wait_until_drained();
      while (pending_items.size() != 0 || req_tvalid || sorted_expect.size() != 0
             || set_count != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_order(input logic mode);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= mode;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      descending = mode;
   endtask

   task automatic set_idling(input int unsigned tx_pct, input int unsigned rx_pct,
                             input logic hold);
      tx_idle_pct <= tx_pct;
      rx_idle_pct <= rx_pct;
      pressure_on <= hold;
      @(negedge clock);
   endtask

   // Sender: a held transaction stays on the bus until it is accepted.
   always @(posedge clock) begin : drive_proc
      heap_word_type next_item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            sort_into_set(req_tdata, req_tlast);
         end
         if (!req_tvalid || req_tready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
               next_item = pending_items.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_item.value;
               req_tlast  <= next_item.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // One long receiver hold in the pressure phase, started once output begins.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (pressure_on && !hold_done && rsp_tvalid) begin
         hold_left <= LONG_HOLD;
         hold_done <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_proc
      heap_word_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (sorted_expect.size() == 0) begin
               $display("%0t: unexpected result: expected none, got value %0d last %0b",
                        $time, $signed(rsp_tdata), rsp_tlast);
               error_count++;
            end else begin
               want = sorted_expect.pop_front();
               if (rsp_tdata !== want.value) begin
                  $display("%0t: value mismatch: expected %0d, got %0d",
                           $time, $signed(want.value), $signed(rsp_tdata));
                  error_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $display("%0t: last flag mismatch: expected %0b, got %0b",
                           $time, want.last, rsp_tlast);
                  error_count++;
               end
            end
         end
         rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("binary_heap_sorter test failed");
         $finish;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Ascending pass: extremes, single-value sets, equal values.
      write_order(ORDER_ASCENDING);
      set_idling(34, 77, 1'b0);
      queue_item(32'h8000_0000, 1'b1);
      queue_item(32'h7FFF_FFFF, 1'b1);
      queue_item(32'h7FFF_FFFF, 1'b0);
      queue_item(32'h8000_0000, 1'b0);
      queue_item(32'h0000_0000, 1'b0);
      queue_item(32'hFFFF_FFFF, 1'b0);
      queue_item(32'h0000_0001, 1'b1);
      queue_item(32'd7, 1'b0);
      queue_item(-32'sd7, 1'b0);
      queue_item(32'd7, 1'b0);
      queue_item(32'd7, 1'b1);
      queue_item(32'hAAAA_AAAA, 1'b0);
      queue_item(32'h5555_5555, 1'b0);
      queue_item(32'h0000_0003, 1'b1);
      queue_random_sets(130);
      wait_until_drained();

      // Descending pass.
      write_order(ORDER_DESCENDING);
      set_idling(77, 34, 1'b0);
      queue_item(32'h8000_0000, 1'b0);
      queue_item(32'h7FFF_FFFF, 1'b0);
      queue_item(32'hFFFF_FFFF, 1'b0);
      queue_item(32'h0000_0000, 1'b1);
      queue_item(-32'sd2, 1'b0);
      queue_item(-32'sd2, 1'b1);
      queue_random_sets(130);
      wait_until_drained();

      // No idling; the receiver stalls long enough to back up the input.
      write_order(ORDER_ASCENDING);
      set_idling(0, 0, 1'b1);
      queue_random_sets(100);
      wait_until_drained();

      write_order(ORDER_DESCENDING);
      set_idling(0, 0, 1'b0);
      queue_random_sets(80);
      wait_until_drained();

      repeat (TAIL_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("binary_heap_sorter test passed");
      end else begin
         $display("binary_heap_sorter test failed");
      end
      $finish;
   end

endmodule
